// File: rtl/cbb_pkg.sv
// ----------------------------------------------------------------------------
// cbb_pkg
// shared codes, widths and the per-request status record of the byte fifo
// ----------------------------------------------------------------------------
package cbb_pkg;

    localparam int CNT_W  = 9;
    localparam int LEN_W  = 4;
    localparam int DATA_W = 64;
    localparam int BYTES  = 8;

    // request modes
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_PEEK  = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // what travels with a transaction from the commit stage to the output
    typedef struct packed {
        logic [1:0]       status;
        logic [CNT_W-1:0] fill;
        logic [CNT_W-1:0] free;
        logic             read_ok;
        logic [LEN_W-1:0] len;
    } cbb_meta_t;

endpackage

// File: rtl/circular_byte_buffer_core.sv
// ----------------------------------------------------------------------------
// circular_byte_buffer_core
// byte fifo with run-time capacity; write, read, peek or clear of up to
// MAX_BURST bytes per transaction
// ----------------------------------------------------------------------------
// The block takes one request per clock while in_ready is high and returns
// one result per request, in order. Each request passes through the request
// register, the commit stage where status is decided, state is updated and
// the byte lanes are accessed, and the output register where lane data is
// put back into byte order. Back-to-back writes and reads run at full rate
// because the store is split into a power-of-two number of byte lanes, each
// a ram with one write and one registered read port, and any run of up to
// that many consecutive positions touches each lane once.
// Writes and reads are all-or-nothing; a write without room or a read/peek
// of more than the stored bytes changes nothing and reports an error with
// zero read data. Lengths above MAX_BURST act as MAX_BURST. A write of the
// capacity register (0 acts as 1, values above DEPTH act as DEPTH) also
// empties the buffer; it must only be issued while no transaction is in
// flight. No clearing pass is needed after reset: only bytes inside the
// fill level are ever read back.
// ----------------------------------------------------------------------------
module circular_byte_buffer_core #(
    parameter int DEPTH     = 256,
    parameter int MAX_BURST = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // request channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  mode,
    input  logic [cbb_pkg::LEN_W-1:0]   length,
    input  logic [cbb_pkg::DATA_W-1:0]  write_data,
    // result channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  status,
    output logic [cbb_pkg::DATA_W-1:0]  read_data,
    output logic [cbb_pkg::CNT_W-1:0]   fill_level,
    output logic [cbb_pkg::CNT_W-1:0]   free_space,
    // capacity register
    input  logic                        cfg_write_en,
    input  logic [cbb_pkg::CNT_W-1:0]   cfg_write_data
);

    // lane count is a power of two at least MAX_BURST (and at least two)
    localparam int LB    = (MAX_BURST <= 2) ? 1 : $clog2(MAX_BURST);
    localparam int LANES = 1 << LB;
    // physical ring wraps naturally; keep at least two rows per lane
    localparam int PW    = ($clog2(DEPTH) > LB) ? $clog2(DEPTH) : LB + 1;
    localparam int RW    = PW - LB;
    localparam int ROWS  = 1 << RW;

    logic                          s2_free;
    logic                          commit;
    cbb_pkg::cbb_meta_t            meta;
    logic [LB-1:0]                 head_lo;
    logic [LANES-1:0]              ram_we;
    logic [LANES-1:0][RW-1:0]      ram_waddr;
    logic [LANES-1:0][7:0]         ram_wdata;
    logic [LANES-1:0][RW-1:0]      ram_raddr;
    logic [LANES-1:0][7:0]         lane_rdata;

    // request register, pointer state and lane addressing
    cbb_front #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST),
        .LB        (LB),
        .PW        (PW)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .length         (length),
        .write_data     (write_data),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .s2_free        (s2_free),
        .commit         (commit),
        .meta           (meta),
        .head_lo        (head_lo),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_raddr      (ram_raddr)
    );

    // one byte-wide ram per lane, all read on every committed transaction
    for (genvar j = 0; j < LANES; j++)
    begin : g_bank
        cbb_ram #(
            .WIDTH (8),
            .DEPTH (ROWS)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we[j]),
            .waddr (ram_waddr[j]),
            .wdata (ram_wdata[j]),
            .re    (commit),
            .raddr (ram_raddr[j]),
            .rdata (lane_rdata[j])
        );
    end

    // lane rotation, masking and result register
    cbb_align #(
        .LB (LB)
    ) u_align (
        .clk        (clk),
        .rst_n      (rst_n),
        .commit     (commit),
        .meta       (meta),
        .head_lo    (head_lo),
        .lane_rdata (lane_rdata),
        .s2_free    (s2_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .read_data  (read_data),
        .fill_level (fill_level),
        .free_space (free_space)
    );

endmodule

// File: rtl/cbb_ram.sv
// ----------------------------------------------------------------------------
// cbb_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module cbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/cbb_front.sv
// ----------------------------------------------------------------------------
// cbb_front
// request register, pointer and count state, status decision and lane
// address generation for the banked byte store
// ----------------------------------------------------------------------------
module cbb_front #(
    parameter int DEPTH     = 256,
    parameter int MAX_BURST = 8,
    parameter int LB        = 3,
    parameter int PW        = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    mode,
    input  logic [cbb_pkg::LEN_W-1:0]     length,
    input  logic [cbb_pkg::DATA_W-1:0]    write_data,
    input  logic                          cfg_write_en,
    input  logic [cbb_pkg::CNT_W-1:0]     cfg_write_data,
    input  logic                          s2_free,
    output logic                          commit,
    output cbb_pkg::cbb_meta_t            meta,
    output logic [LB-1:0]                 head_lo,
    output logic [(1<<LB)-1:0]            ram_we,
    output logic [(1<<LB)-1:0][PW-LB-1:0] ram_waddr,
    output logic [(1<<LB)-1:0][7:0]       ram_wdata,
    output logic [(1<<LB)-1:0][PW-LB-1:0] ram_raddr
);

    localparam int LANES     = 1 << LB;
    localparam int CAP_RESET = (DEPTH < 256) ? DEPTH : 256;

    logic                        s1_valid_reg;
    logic [1:0]                  s1_mode_reg;
    logic [cbb_pkg::LEN_W-1:0]   s1_len_reg;
    logic [cbb_pkg::DATA_W-1:0]  s1_wdata_reg;

    logic [PW-1:0]               head_reg;
    logic [PW-1:0]               head_next;
    logic [cbb_pkg::CNT_W-1:0]   count_reg;
    logic [cbb_pkg::CNT_W-1:0]   count_next;
    logic [cbb_pkg::CNT_W-1:0]   cap_reg;
    logic [cbb_pkg::CNT_W-1:0]   cap_eff;

    logic [cbb_pkg::LEN_W-1:0]   len_sat;
    logic [cbb_pkg::CNT_W-1:0]   len_ext;
    logic [cbb_pkg::CNT_W-1:0]   room;
    logic [PW-1:0]               tail;
    logic [1:0]                  status_c;
    logic                        write_ok;
    logic                        is_write;

    assign len_sat = (length > cbb_pkg::LEN_W'(MAX_BURST)) ?
                     cbb_pkg::LEN_W'(MAX_BURST) : length;

    always_comb
    begin
        if (cfg_write_data == '0)
        begin
            cap_eff = cbb_pkg::CNT_W'(1);
        end
        else if (32'(cfg_write_data) > DEPTH)
        begin
            cap_eff = cbb_pkg::CNT_W'(DEPTH);
        end
        else
        begin
            cap_eff = cfg_write_data;
        end
    end

    assign commit   = s1_valid_reg && s2_free;
    assign in_ready = !s1_valid_reg || s2_free;

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_mode_reg  <= mode;
            s1_len_reg   <= len_sat;
            s1_wdata_reg <= write_data;
        end
    end

    // status and next state
    assign len_ext = cbb_pkg::CNT_W'(s1_len_reg);
    assign room    = cap_reg - count_reg;
    assign tail    = head_reg + PW'(count_reg);

    always_comb
    begin
        status_c   = cbb_pkg::ST_OK;
        head_next  = head_reg;
        count_next = count_reg;
        case (s1_mode_reg)
            cbb_pkg::MODE_WRITE:
            begin
                if (len_ext > room)
                begin
                    status_c = cbb_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + len_ext;
                end
            end
            cbb_pkg::MODE_READ:
            begin
                if (len_ext > count_reg)
                begin
                    status_c = cbb_pkg::ST_EMPTY;
                end
                else
                begin
                    head_next  = head_reg + PW'(s1_len_reg);
                    count_next = count_reg - len_ext;
                end
            end
            cbb_pkg::MODE_PEEK:
            begin
                if (len_ext > count_reg)
                begin
                    status_c = cbb_pkg::ST_EMPTY;
                end
            end
            default:
            begin
                head_next  = '0;
                count_next = '0;
            end
        endcase
    end

    assign is_write = (s1_mode_reg == cbb_pkg::MODE_WRITE);
    assign write_ok = is_write && (status_c == cbb_pkg::ST_OK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            cap_reg   <= cbb_pkg::CNT_W'(CAP_RESET);
        end
        else if (cfg_write_en)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            cap_reg   <= cap_eff;
        end
        else if (commit)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    assign meta.status  = status_c;
    assign meta.fill    = count_next;
    assign meta.free    = cap_reg - count_next;
    assign meta.read_ok = ((s1_mode_reg == cbb_pkg::MODE_READ) ||
                           (s1_mode_reg == cbb_pkg::MODE_PEEK)) &&
                          (status_c == cbb_pkg::ST_OK);
    assign meta.len     = s1_len_reg;
    assign head_lo      = head_reg[LB-1:0];

    // lane j holds every position whose low bits equal j
    for (genvar j = 0; j < LANES; j++)
    begin : g_lane
        logic [LB-1:0] woffs;
        logic [LB-1:0] roffs;
        logic [PW-1:0] wpos;
        logic [PW-1:0] rpos;

        assign woffs = LB'(j) - tail[LB-1:0];
        assign roffs = LB'(j) - head_reg[LB-1:0];
        assign wpos  = tail + PW'(woffs);
        assign rpos  = head_reg + PW'(roffs);

        assign ram_we[j]    = commit && write_ok &&
                              (cbb_pkg::LEN_W'(woffs) < s1_len_reg);
        assign ram_waddr[j] = wpos[PW-1:LB];
        assign ram_raddr[j] = rpos[PW-1:LB];
        assign ram_wdata[j] = s1_wdata_reg[{woffs, 3'b000} +: 8];
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cap_reg)
        else $error("byte count above capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cap_reg != '0) && (32'(cap_reg) <= DEPTH))
        else $error("capacity register out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        commit && (status_c != cbb_pkg::ST_OK) |-> (ram_we == '0))
        else $error("store written by a failed request");

    assert property (@(posedge clk) disable iff (!rst_n)
        commit && (status_c != cbb_pkg::ST_OK) && !cfg_write_en
        |=> $stable(count_reg) && $stable(head_reg))
        else $error("state changed by a failed request");

endmodule

// File: rtl/cbb_align.sv
// ----------------------------------------------------------------------------
// cbb_align
// holds the committed transaction while lane data returns, then rotates
// the lanes into byte order, masks unused bytes and registers the result
// ----------------------------------------------------------------------------
module cbb_align #(
    parameter int LB = 3
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           commit,
    input  cbb_pkg::cbb_meta_t             meta,
    input  logic [LB-1:0]                  head_lo,
    input  logic [(1<<LB)-1:0][7:0]        lane_rdata,
    output logic                           s2_free,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     status,
    output logic [cbb_pkg::DATA_W-1:0]     read_data,
    output logic [cbb_pkg::CNT_W-1:0]      fill_level,
    output logic [cbb_pkg::CNT_W-1:0]      free_space
);

    logic                          s2_valid_reg;
    cbb_pkg::cbb_meta_t            s2_meta_reg;
    logic [LB-1:0]                 s2_head_lo_reg;
    logic                          out_valid_reg;
    logic [1:0]                    status_reg;
    logic [cbb_pkg::DATA_W-1:0]    read_data_reg;
    logic [cbb_pkg::CNT_W-1:0]     fill_reg;
    logic [cbb_pkg::CNT_W-1:0]     free_reg;
    logic [cbb_pkg::DATA_W-1:0]    rdata_c;
    logic                          adv;

    assign adv     = s2_valid_reg && (!out_valid_reg || out_ready);
    assign s2_free = !s2_valid_reg || !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (commit)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            s2_meta_reg    <= meta;
            s2_head_lo_reg <= head_lo;
        end
        if (adv)
        begin
            status_reg    <= s2_meta_reg.status;
            read_data_reg <= rdata_c;
            fill_reg      <= s2_meta_reg.fill;
            free_reg      <= s2_meta_reg.free;
        end
    end

    // byte i sits in the lane just past the head lane by i
    always_comb
    begin
        for (int i = 0; i < cbb_pkg::BYTES; i++)
        begin
            if (s2_meta_reg.read_ok && (cbb_pkg::LEN_W'(i) < s2_meta_reg.len))
            begin
                rdata_c[8*i +: 8] = lane_rdata[LB'(i) + s2_head_lo_reg];
            end
            else
            begin
                rdata_c[8*i +: 8] = 8'h00;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign read_data  = read_data_reg;
    assign fill_level = fill_reg;
    assign free_space = free_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg != cbb_pkg::ST_OK) |-> (read_data_reg == '0))
        else $error("failed request returned data");

endmodule
